// File: design/agm_pkg.sv
// shared types, codes and constants of the auto-growing key row map
package agm_pkg;

   localparam int MAX_ROWS_DEF             = 1024;
   localparam int MAX_KEYS_PER_REQUEST_DEF = 65536;

   localparam int KEY_W    = 64;
   localparam int STATUS_W = 3;
   localparam int ROWIDX_W = 10;
   localparam int SRCOFF_W = 22;
   localparam int DSTOFF_W = 28;
   localparam int POSOFF_W = 16;
   localparam int CAP_W    = 11;
   localparam int WIDTH_W  = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_FILL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_GROW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEST_MODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_CAPACITY = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH    = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESOLVE,
      S_MUL
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic resolve;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } sts_type;

endpackage

// File: design/agm_chan_if.sv
// request and response channel interfaces
interface agm_req_if;
   import agm_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] key;
   logic                    last_key;
   modport source (output valid, key, last_key, input ready);
   modport sink   (input valid, key, last_key, output ready);
endinterface

interface agm_rsp_if;
   import agm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [ROWIDX_W-1:0]   row_index;
   logic [SRCOFF_W-1:0]   source_offset;
   logic [DSTOFF_W-1:0]   dest_offset;
   logic                  zero_fill;
   logic                  last_result;
   modport source (output valid, status, row_index, source_offset, dest_offset,
                   zero_fill, last_result, input ready);
   modport sink   (input valid, status, row_index, source_offset, dest_offset,
                   zero_fill, last_result, output ready);
endinterface

// File: design/agm_ctrl.sv
// controller state machine for the key row map
module agm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  agm_pkg::sts_type   sts,
   output agm_pkg::cmd_type   cmd,
   output agm_pkg::state_type state
);
   import agm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_SCAN;
         S_SCAN:    if (sts.scan_done) state_in = S_RESOLVE;
         S_RESOLVE: state_in = S_MUL;
         S_MUL:     if (sts.rsp_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         S_SCAN:    cmd.scan = 1'b1;
         S_RESOLVE: cmd.resolve = 1'b1;
         S_MUL:     cmd.load = sts.rsp_free;
         default:   cmd = '0;
      endcase
   end

   assign state = state_ff;
endmodule

// File: design/agm_dp.sv
// datapath: config registers, key store, scan, decision and offset multiply
module agm_dp #(
   parameter int MAX_ROWS             = agm_pkg::MAX_ROWS_DEF,
   parameter int MAX_KEYS_PER_REQUEST = agm_pkg::MAX_KEYS_PER_REQUEST_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [agm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [agm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic signed [agm_pkg::KEY_W-1:0]    req_key,
   input  logic                                req_last_key,
   input  agm_pkg::cmd_type                    cmd,
   output agm_pkg::sts_type                    sts,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [agm_pkg::STATUS_W-1:0]        rsp_status,
   output logic [agm_pkg::ROWIDX_W-1:0]        rsp_row_index,
   output logic [agm_pkg::SRCOFF_W-1:0]        rsp_source_offset,
   output logic [agm_pkg::DSTOFF_W-1:0]        rsp_dest_offset,
   output logic                                rsp_zero_fill,
   output logic                                rsp_last_result
);
   import agm_pkg::*;

   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = $clog2(MAX_ROWS + 1);
   localparam int PW = $clog2(MAX_KEYS_PER_REQUEST);

   // config
   logic               auto_grow_ff, test_mode_ff;
   logic [CAP_W-1:0]   row_capacity_ff;
   logic [WIDTH_W-1:0] row_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_grow_ff    <= 1'b0;
         test_mode_ff    <= 1'b0;
         row_capacity_ff <= CAP_W'(1024);
         row_width_ff    <= WIDTH_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_AUTO_GROW:    auto_grow_ff    <= csr_wdata[0];
            CSR_TEST_MODE:    test_mode_ff    <= csr_wdata[0];
            CSR_ROW_CAPACITY: row_capacity_ff <= csr_wdata[CAP_W-1:0];
            CSR_ROW_WIDTH:    row_width_ff    <= csr_wdata[WIDTH_W-1:0];
            default:          auto_grow_ff    <= auto_grow_ff;
         endcase
      end
   end

   // key store
   logic [KEY_W-1:0] mem [MAX_ROWS];

   logic [CW-1:0]    count_ff;
   logic [PW-1:0]    pos_ff;
   logic [KEY_W-1:0] key_ff;
   logic             last_ff;
   logic [CW-1:0]    rd_idx_ff;
   logic             cmp_vld_ff;
   logic [AW-1:0]    cmp_idx_ff;
   logic [KEY_W-1:0] rdata_ff;
   logic             found_ff;
   logic [AW-1:0]    found_row_ff;

   logic hit, issue;
   assign hit   = cmp_vld_ff && (rdata_ff == key_ff) && !found_ff;
   assign issue = cmd.scan && !found_ff && !hit && (rd_idx_ff < count_ff);

   assign sts.scan_done = found_ff || (!cmp_vld_ff && (rd_idx_ff >= count_ff));

   always_ff @(posedge clock) begin
      if (issue) rdata_ff <= mem[rd_idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff  <= req_key;
         last_ff <= req_last_key;
      end
      if (issue) cmp_idx_ff <= rd_idx_ff[AW-1:0];
      if (hit)   found_row_ff <= cmp_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else if (cmd.start) begin
         rd_idx_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         cmp_vld_ff <= issue;
         if (issue) rd_idx_ff <= rd_idx_ff + CW'(1);
         if (hit)   found_ff  <= 1'b1;
      end
   end

   // decision
   logic [31:0]   cap;
   logic          insert;
   logic [PW-1:0] pos_in;
   assign cap    = (32'(row_capacity_ff) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS)
                                                          : 32'(row_capacity_ff);
   assign insert = !found_ff && !test_mode_ff && auto_grow_ff && (32'(count_ff) < cap);
   assign pos_in = (last_ff || (32'(pos_ff) + 32'd1 >= 32'(MAX_KEYS_PER_REQUEST)))
                   ? '0 : pos_ff + PW'(1);

   always_ff @(posedge clock) begin
      if (cmd.resolve && insert) mem[count_ff[AW-1:0]] <= key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
      end else if (cmd.resolve) begin
         if (insert) count_ff <= count_ff + CW'(1);
         pos_ff <= pos_in;
      end
   end

   logic [STATUS_W-1:0] res_status_ff;
   logic [AW-1:0]       res_row_ff;
   logic                res_valid_ff;
   logic [POSOFF_W-1:0] res_pos_ff;
   logic                res_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         res_pos_ff  <= POSOFF_W'(pos_ff);
         res_last_ff <= last_ff;
         if (found_ff) begin
            res_status_ff <= ST_HIT;
            res_row_ff    <= found_row_ff;
            res_valid_ff  <= 1'b1;
         end else if (test_mode_ff) begin
            res_status_ff <= ST_ZERO_FILL;
            res_row_ff    <= '0;
            res_valid_ff  <= 1'b0;
         end else if (!auto_grow_ff) begin
            res_status_ff <= ST_NOT_FOUND;
            res_row_ff    <= '0;
            res_valid_ff  <= 1'b0;
         end else if (!insert) begin
            res_status_ff <= ST_FULL;
            res_row_ff    <= '0;
            res_valid_ff  <= 1'b0;
         end else begin
            res_status_ff <= ST_INSERTED;
            res_row_ff    <= count_ff[AW-1:0];
            res_valid_ff  <= 1'b1;
         end
      end
   end

   // offsets and output register
   logic [31:0] src_prod, dst_prod;
   assign src_prod = 32'(res_row_ff) * 32'(row_width_ff);
   assign dst_prod = 32'(res_pos_ff) * 32'(row_width_ff);

   logic rsp_valid_ff;
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset)         rsp_valid_ff <= 1'b0;
      else if (cmd.load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status        <= res_status_ff;
         rsp_row_index     <= ROWIDX_W'(res_row_ff);
         rsp_source_offset <= res_valid_ff ? src_prod[SRCOFF_W-1:0] : '0;
         rsp_dest_offset   <= dst_prod[DSTOFF_W-1:0];
         rsp_zero_fill     <= (res_status_ff == ST_ZERO_FILL);
         rsp_last_result   <= res_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// File: design/auto_grow_key_row_map.sv
// a request that is taken is scanned against the store, resolved and then loaded into the output
//   register once that is free; a hit ends the scan at its row; one request at a time
// scan: the key store is scanned one entry per cycle through its single read port
//   until a hit or the last entry, so a miss scans every entry
// a finished response waits in the output register while the next request is scanned
// synchronous active-high reset empties the map, zeroes the request position and
//   restores auto_grow 0, test_mode 0, row_capacity 1024, row_width 1; no clearing pass
module auto_grow_key_row_map #(
   parameter int MAX_ROWS             = agm_pkg::MAX_ROWS_DEF,
   parameter int MAX_KEYS_PER_REQUEST = agm_pkg::MAX_KEYS_PER_REQUEST_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   agm_req_if.sink                        req_chan,
   agm_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [agm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [agm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import agm_pkg::*;

   cmd_type   cmd;
   sts_type   sts;
   state_type state;

   // controller: idle -> scan the store -> resolve hit/insert/error -> multiply offsets
   agm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd),
      .state     (state)
   );

   // datapath: key store memory, entry count, request position, offset products
   agm_dp #(
      .MAX_ROWS             (MAX_ROWS),
      .MAX_KEYS_PER_REQUEST (MAX_KEYS_PER_REQUEST)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_key           (req_chan.key),
      .req_last_key      (req_chan.last_key),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_row_index     (rsp_chan.row_index),
      .rsp_source_offset (rsp_chan.source_offset),
      .rsp_dest_offset   (rsp_chan.dest_offset),
      .rsp_zero_fill     (rsp_chan.zero_fill),
      .rsp_last_result   (rsp_chan.last_result)
   );

   // a request that is taken in always starts a scan
   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state == S_SCAN) else $error("request taken without scan");

   // at most one datapath command per cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.scan, cmd.resolve, cmd.load}))
      else $error("overlapping datapath commands");

   // resolve is always followed directly by the multiply step in the next cycle
   a_resolve_mul: assert property (@(posedge clock) disable iff (reset)
      state == S_RESOLVE |=> state == S_MUL) else $error("resolve not followed by multiply");

   // zero fill is flagged exactly for the zero-fill status
   a_zero_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.zero_fill == (rsp_chan.status == ST_ZERO_FILL)))
      else $error("zero_fill disagrees with status");
endmodule
